// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the column store modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while reset is held.
`define CHECK_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Clocked implication, off while reset is held.
`define CHECK_IMPL(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

`endif

// ===== hdl/ssc_pkg.sv =====
// Types, constants and codes of the sparse-set column store.
package ssc_pkg;

	localparam int NUM_COLUMNS = 4;
	localparam int MAX_IDS     = 1024;
	localparam int VALUE_WIDTH = 16;

	localparam int ID_W    = 10;
	localparam int COL_W   = 2;
	localparam int CNT_W   = ID_W + 1;
	localparam int SLOT_W  = COL_W + ID_W;
	localparam int SLOTS   = 1 << SLOT_W;
	localparam int SLICE_W = 16;
	localparam int DATA_W  = 4 * SLICE_W;

	typedef enum logic [1:0] {
		KIND_UPDATE = 2'd0,
		KIND_ERASE  = 2'd1,
		KIND_LOOKUP = 2'd2,
		KIND_SURVEY = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_MISS  = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	typedef enum logic [4:0] {
		CMD_NONE,
		CMD_CLEAR,
		CMD_LOAD,
		CMD_SP_RD,
		CMD_SP_RD_GUIDE,
		CMD_UPD_WR,
		CMD_ER_RD_LAST,
		CMD_ER_MOVE,
		CMD_ER_INVAL,
		CMD_LK_RD_VAL,
		CMD_LK_ACC,
		CMD_COL_NEXT,
		CMD_SV_POS,
		CMD_SV_RD_ID,
		CMD_SV_CAND,
		CMD_POS_NEXT,
		CMD_RES_OK,
		CMD_RES_DONE,
		CMD_RES_MISS,
		CMD_RES_RANGE
	} cmd_t;

	typedef enum logic [4:0] {
		S_CLEAR,
		S_IDLE,
		S_DISPATCH,
		S_U_CHK,
		S_U_WR,
		S_U_NEXT,
		S_E_CHK,
		S_E_RD,
		S_E_MV,
		S_E_INV,
		S_E_NEXT,
		S_G_CHK,
		S_G_RD,
		S_G_ACC,
		S_G_NEXT,
		S_S_START,
		S_S_POS,
		S_S_LOOP,
		S_S_CAND,
		S_S_SKIP,
		S_R_OK,
		S_R_DONE,
		S_R_MISS,
		S_R_RANGE
	} state_t;

	typedef struct packed {
		kind_t kind;
		logic  from_start;
		logic  id_ok;
		logic  guide_ok;
		logic  in_mask;
		logic  col_last;
		logic  sp_valid;
		logic  cnt_nonzero;
		logic  pos_lt_lim;
		logic  clear_done;
		logic  out_free;
	} dp_status_t;

endpackage

// ===== hdl/sparse_set_column_store.sv =====
// Sequence: an accepted word is dispatched, then each column is visited in turn; update
// writes a masked column, a lookup hit reads it (a miss ends at the first absent column),
// and erase, where the id is held, reads the last entry, moves it to the hole, clears the slot.
// Survey walks guide entries until one holds all masked columns. A held result word waits.
// Flow: one word in flight; the next is taken from the cycle after the result is loaded.
// Reset: counts and control clear at once; a pass clears all 4096 sparse slots, in_stall high.
module sparse_set_column_store import ssc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        kind,
	input  logic [ID_W-1:0]   entity_id,
	input  logic              from_start,
	input  logic [3:0]        column_mask,
	input  logic [COL_W-1:0]  guide_column,
	input  logic [DATA_W-1:0] value_in,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [1:0]        status,
	output logic [ID_W-1:0]   found_id,
	output logic [DATA_W-1:0] value_out
);

	cmd_t       cmd;
	dp_status_t st;

	ssc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.st       (st),
		.cmd      (cmd)
	);

	ssc_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.st           (st),
		.kind         (kind),
		.entity_id    (entity_id),
		.from_start   (from_start),
		.column_mask  (column_mask),
		.guide_column (guide_column),
		.value_in     (value_in),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.found_id     (found_id),
		.value_out    (value_out)
	);

endmodule

// ===== hdl/ssc_ctrl.sv =====
// Controller state machine sequencing the column store datapath.
`include "assert_macros.svh"
module ssc_ctrl import ssc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  dp_status_t st,
	output cmd_t       cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				if (st.clear_done) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) state_d = S_DISPATCH;
			end
			S_DISPATCH: begin
				if (st.kind == KIND_SURVEY) state_d = S_S_START;
				else if (!st.id_ok) state_d = S_R_RANGE;
				else if (st.kind == KIND_UPDATE) state_d = S_U_CHK;
				else if (st.kind == KIND_ERASE) state_d = S_E_CHK;
				else state_d = S_G_CHK;
			end
			S_U_CHK: state_d = st.in_mask ? S_U_WR : S_U_NEXT;
			S_U_WR:  state_d = S_U_NEXT;
			S_U_NEXT: state_d = st.col_last ? S_R_DONE : S_U_CHK;
			S_E_CHK: state_d = st.in_mask ? S_E_RD : S_E_NEXT;
			S_E_RD:  state_d = (st.sp_valid && st.cnt_nonzero) ? S_E_MV : S_E_NEXT;
			S_E_MV:  state_d = S_E_INV;
			S_E_INV: state_d = S_E_NEXT;
			S_E_NEXT: state_d = st.col_last ? S_R_DONE : S_E_CHK;
			S_G_CHK: state_d = st.in_mask ? S_G_RD : S_G_NEXT;
			S_G_RD: begin
				if (st.sp_valid) state_d = S_G_ACC;
				else if (st.kind == KIND_SURVEY) state_d = S_S_SKIP;
				else state_d = S_R_MISS;
			end
			S_G_ACC: state_d = S_G_NEXT;
			S_G_NEXT: state_d = st.col_last ? S_R_OK : S_G_CHK;
			S_S_START: begin
				if (!st.from_start && !st.id_ok) state_d = S_R_RANGE;
				else if (!st.guide_ok) state_d = S_R_MISS;
				else state_d = S_S_POS;
			end
			S_S_POS:  state_d = S_S_LOOP;
			S_S_LOOP: state_d = st.pos_lt_lim ? S_S_CAND : S_R_MISS;
			S_S_CAND: state_d = S_G_CHK;
			S_S_SKIP: state_d = S_S_LOOP;
			S_R_OK, S_R_DONE, S_R_MISS, S_R_RANGE: begin
				if (st.out_free) state_d = S_IDLE;
			end
			default: state_d = S_CLEAR;
		endcase
	end

	always_comb begin
		cmd = CMD_NONE;
		case (state_q)
			S_CLEAR:  cmd = CMD_CLEAR;
			S_IDLE:   cmd = in_valid ? CMD_LOAD : CMD_NONE;
			S_U_CHK, S_E_CHK, S_G_CHK: cmd = st.in_mask ? CMD_SP_RD : CMD_NONE;
			S_U_WR:   cmd = CMD_UPD_WR;
			S_E_RD:   cmd = (st.sp_valid && st.cnt_nonzero) ? CMD_ER_RD_LAST : CMD_NONE;
			S_E_MV:   cmd = CMD_ER_MOVE;
			S_E_INV:  cmd = CMD_ER_INVAL;
			S_U_NEXT, S_E_NEXT, S_G_NEXT: cmd = st.col_last ? CMD_NONE : CMD_COL_NEXT;
			S_G_RD:   cmd = st.sp_valid ? CMD_LK_RD_VAL : CMD_NONE;
			S_G_ACC:  cmd = CMD_LK_ACC;
			S_S_START: begin
				if ((st.from_start || st.id_ok) && st.guide_ok) cmd = CMD_SP_RD_GUIDE;
			end
			S_S_POS:  cmd = CMD_SV_POS;
			S_S_LOOP: cmd = st.pos_lt_lim ? CMD_SV_RD_ID : CMD_NONE;
			S_S_CAND: cmd = CMD_SV_CAND;
			S_S_SKIP: cmd = CMD_POS_NEXT;
			S_R_OK:    cmd = st.out_free ? CMD_RES_OK : CMD_NONE;
			S_R_DONE:  cmd = st.out_free ? CMD_RES_DONE : CMD_NONE;
			S_R_MISS:  cmd = st.out_free ? CMD_RES_MISS : CMD_NONE;
			S_R_RANGE: cmd = st.out_free ? CMD_RES_RANGE : CMD_NONE;
			default:  cmd = CMD_NONE;
		endcase
	end

	`CHECK_IMPL(a_accept_dispatch, in_valid && !in_stall, ##1 state_q == S_DISPATCH, "accept did not dispatch")
	`CHECK_IMPL(a_no_accept_in_clear, !st.clear_done, in_stall, "input taken during clear pass")
	`CHECK_IMPL(a_result_room, cmd == CMD_RES_OK || cmd == CMD_RES_MISS, st.out_free, "result issued onto held word")

endmodule

// ===== hdl/ssc_datapath.sv =====
// Datapath of the column store: sparse, dense id and value memories, counts, result register.
`include "assert_macros.svh"
module ssc_datapath import ssc_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cmd_t                   cmd,
	output dp_status_t             st,
	input  logic [1:0]             kind,
	input  logic [ID_W-1:0]        entity_id,
	input  logic                   from_start,
	input  logic [3:0]             column_mask,
	input  logic [COL_W-1:0]       guide_column,
	input  logic [DATA_W-1:0]      value_in,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [1:0]             status,
	output logic [ID_W-1:0]        found_id,
	output logic [DATA_W-1:0]      value_out
);

	logic [ID_W:0]          sp_mem [SLOTS];
	logic [ID_W-1:0]        id_mem [SLOTS];
	logic [VALUE_WIDTH-1:0] vl_mem [SLOTS];

	logic [CNT_W-1:0] cnt_q [NUM_COLUMNS];

	kind_t             kind_q;
	logic [ID_W-1:0]   key_q, cand_q, hole_q;
	logic              from_start_q;
	logic [3:0]        mask_q;
	logic [COL_W-1:0]  guide_q, col_q;
	logic [DATA_W-1:0] vin_q, acc_q;
	logic [CNT_W-1:0]  pos_q, lim_q;
	logic [ID_W:0]     sp_rd_q;
	logic [ID_W-1:0]   id_rd_q;
	logic [VALUE_WIDTH-1:0] vl_rd_q;
	logic [SLOT_W-1:0] clr_q;
	logic              clr_done_q, out_valid_q;
	status_t           status_q;
	logic [ID_W-1:0]   found_q;
	logic [DATA_W-1:0] vout_q;

	logic              sp_we, sp_re, id_we, id_re, vl_we, vl_re;
	logic [SLOT_W-1:0] sp_waddr, sp_raddr, id_waddr, id_raddr, vl_waddr, vl_raddr;
	logic [ID_W:0]     sp_wdata;
	logic [ID_W-1:0]   id_wdata;
	logic [VALUE_WIDTH-1:0] vl_wdata, vin_slice;
	logic [CNT_W-1:0]  cur_cnt, cnt_m1;
	logic [ID_W-1:0]   sp_pos;
	logic              sp_vld, room, out_free, cnt_ok;

	assign cur_cnt   = cnt_q[col_q];
	assign cnt_m1    = cur_cnt - CNT_W'(1);
	assign sp_pos    = sp_rd_q[ID_W-1:0];
	assign sp_vld    = sp_rd_q[ID_W];
	assign room      = cur_cnt < CNT_W'(MAX_IDS);
	assign vin_slice = vin_q[int'(col_q) * SLICE_W +: VALUE_WIDTH];
	assign out_free  = !out_valid_q || !out_stall;

	always_comb begin
		sp_we = 1'b0; sp_re = 1'b0; id_we = 1'b0; id_re = 1'b0; vl_we = 1'b0; vl_re = 1'b0;
		sp_waddr = '0; sp_raddr = '0; id_waddr = '0; id_raddr = '0;
		vl_waddr = '0; vl_raddr = '0;
		sp_wdata = '0; id_wdata = key_q; vl_wdata = vin_slice;
		case (cmd)
			CMD_CLEAR: begin
				sp_we = 1'b1; sp_waddr = clr_q;
			end
			CMD_SP_RD: begin
				sp_re = 1'b1; sp_raddr = {col_q, cand_q};
			end
			CMD_SP_RD_GUIDE: begin
				sp_re = 1'b1; sp_raddr = {guide_q, key_q};
			end
			CMD_UPD_WR: begin
				if (sp_vld) begin
					vl_we = 1'b1; vl_waddr = {col_q, sp_pos};
				end else if (room) begin
					// append to the dense end and point the sparse slot at it
					id_we = 1'b1; id_waddr = {col_q, cur_cnt[ID_W-1:0]};
					vl_we = 1'b1; vl_waddr = {col_q, cur_cnt[ID_W-1:0]};
					sp_we = 1'b1; sp_waddr = {col_q, key_q};
					sp_wdata = {1'b1, cur_cnt[ID_W-1:0]};
				end
			end
			CMD_ER_RD_LAST: begin
				id_re = 1'b1; id_raddr = {col_q, cnt_m1[ID_W-1:0]};
				vl_re = 1'b1; vl_raddr = {col_q, cnt_m1[ID_W-1:0]};
			end
			CMD_ER_MOVE: begin
				// move the last word into the hole
				id_we = 1'b1; id_waddr = {col_q, hole_q}; id_wdata = id_rd_q;
				vl_we = 1'b1; vl_waddr = {col_q, hole_q}; vl_wdata = vl_rd_q;
				sp_we = 1'b1; sp_waddr = {col_q, id_rd_q}; sp_wdata = {1'b1, hole_q};
			end
			CMD_ER_INVAL: begin
				sp_we = 1'b1; sp_waddr = {col_q, cand_q};
			end
			CMD_LK_RD_VAL: begin
				vl_re = 1'b1; vl_raddr = {col_q, sp_pos};
			end
			CMD_SV_RD_ID: begin
				id_re = 1'b1; id_raddr = {guide_q, pos_q[ID_W-1:0]};
			end
			default: begin
				sp_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (sp_we) sp_mem[sp_waddr] <= sp_wdata;
		if (sp_re) sp_rd_q <= sp_mem[sp_raddr];
	end

	always_ff @(posedge clk) begin
		if (id_we) id_mem[id_waddr] <= id_wdata;
		if (id_re) id_rd_q <= id_mem[id_raddr];
	end

	always_ff @(posedge clk) begin
		if (vl_we) vl_mem[vl_waddr] <= vl_wdata;
		if (vl_re) vl_rd_q <= vl_mem[vl_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			clr_done_q  <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < NUM_COLUMNS; i++) cnt_q[i] <= '0;
		end else begin
			if (cmd == CMD_CLEAR) begin
				clr_q <= clr_q + SLOT_W'(1);
				if (clr_q == SLOT_W'(SLOTS - 1)) clr_done_q <= 1'b1;
			end
			if (cmd == CMD_UPD_WR && !sp_vld && room) cnt_q[col_q] <= cur_cnt + CNT_W'(1);
			if (cmd == CMD_ER_RD_LAST) cnt_q[col_q] <= cnt_m1;
			if (cmd == CMD_RES_OK || cmd == CMD_RES_DONE || cmd == CMD_RES_MISS
					|| cmd == CMD_RES_RANGE) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (cmd)
			CMD_LOAD: begin
				kind_q       <= kind_t'(kind);
				key_q        <= entity_id;
				cand_q       <= entity_id;
				from_start_q <= from_start;
				mask_q       <= column_mask;
				guide_q      <= guide_column;
				vin_q        <= value_in;
				col_q        <= '0;
				acc_q        <= '0;
			end
			CMD_SP_RD_GUIDE: col_q <= guide_q;
			CMD_ER_RD_LAST:  hole_q <= sp_pos;
			CMD_LK_ACC: acc_q[int'(col_q) * SLICE_W +: SLICE_W] <= SLICE_W'(vl_rd_q);
			CMD_COL_NEXT: col_q <= col_q + COL_W'(1);
			CMD_SV_POS: begin
				// continue after the id, or start over when it is absent or from_start is set
				pos_q <= (!from_start_q && sp_vld) ? CNT_W'(sp_pos) + CNT_W'(1) : '0;
				lim_q <= cur_cnt;
			end
			CMD_SV_RD_ID: begin
				col_q <= '0;
				acc_q <= '0;
			end
			CMD_SV_CAND:  cand_q <= id_rd_q;
			CMD_POS_NEXT: pos_q <= pos_q + CNT_W'(1);
			CMD_RES_OK: begin
				status_q <= ST_OK; found_q <= cand_q; vout_q <= acc_q;
			end
			CMD_RES_DONE: begin
				status_q <= ST_OK; found_q <= '0; vout_q <= '0;
			end
			CMD_RES_MISS: begin
				status_q <= ST_MISS; found_q <= '0; vout_q <= '0;
			end
			CMD_RES_RANGE: begin
				status_q <= ST_RANGE; found_q <= '0; vout_q <= '0;
			end
			default: begin
				hole_q <= hole_q;
			end
		endcase
	end

	always_comb begin
		st.kind        = kind_q;
		st.from_start  = from_start_q;
		st.id_ok       = (CNT_W'(key_q) < CNT_W'(MAX_IDS));
		st.guide_ok    = (int'(guide_q) < NUM_COLUMNS);
		st.in_mask     = mask_q[col_q];
		st.col_last    = (col_q == COL_W'(NUM_COLUMNS - 1));
		st.sp_valid    = sp_vld;
		st.cnt_nonzero = (cur_cnt != '0);
		st.pos_lt_lim  = (pos_q < lim_q);
		st.clear_done  = clr_done_q;
		st.out_free    = out_free;
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign found_id  = found_q;
	assign value_out = vout_q;

	assign cnt_ok = (cnt_q[0] <= CNT_W'(MAX_IDS)) && (cnt_q[1] <= CNT_W'(MAX_IDS))
		&& (cnt_q[2] <= CNT_W'(MAX_IDS)) && (cnt_q[3] <= CNT_W'(MAX_IDS));

	`CHECK_CLK(a_count_bound, cnt_ok, "column count beyond capacity")
	`CHECK_IMPL(a_no_write_during_read, sp_we, !sp_re, "sparse port read and written together")
	`CHECK_IMPL(a_erase_has_entry, cmd == CMD_ER_RD_LAST, sp_vld && cur_cnt != '0, "erase of empty slot")

endmodule

// ===== dv/sparse_set_column_store_checker.sv =====
// Checker for the sparse-set column store: predicts every result word and compares it.
`timescale 1ns / 100ps
module sparse_set_column_store_checker import ssc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic [1:0]        kind,
	input  logic [ID_W-1:0]   entity_id,
	input  logic              from_start,
	input  logic [3:0]        column_mask,
	input  logic [COL_W-1:0]  guide_column,
	input  logic [DATA_W-1:0] value_in,
	input  logic              out_valid,
	input  logic              out_stall,
	input  logic [1:0]        status,
	input  logic [ID_W-1:0]   found_id,
	input  logic [DATA_W-1:0] value_out,
	output int                fail_count,
	output int                pending
);

	typedef struct packed {
		logic [1:0]        st;
		logic [ID_W-1:0]   id;
		logic [DATA_W-1:0] vals;
	} answer_t;

	answer_t answer_q[$];

	logic              held[NUM_COLUMNS][MAX_IDS];
	logic [CNT_W-1:0]  where[NUM_COLUMNS][MAX_IDS];
	logic [ID_W-1:0]   id_list[NUM_COLUMNS][MAX_IDS];
	logic [SLICE_W-1:0] val_list[NUM_COLUMNS][MAX_IDS];
	logic [CNT_W-1:0]  fill[NUM_COLUMNS];

	assign pending = answer_q.size();

	task automatic report(input string what, input logic [DATA_W-1:0] got,
		input logic [DATA_W-1:0] want);
		$display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	function automatic logic collect(input int ent, input logic [3:0] m,
		output logic [DATA_W-1:0] acc);
		acc = '0;
		for (int c = 0; c < NUM_COLUMNS; c++) begin
			if (m[c]) begin
				if (!held[c][ent])
					return 1'b0;
				acc[16*c +: 16] = val_list[c][where[c][ent]];
			end
		end
		return 1'b1;
	endfunction

	task automatic apply(input kind_t k, input int ent, input logic fs,
		input logic [3:0] m, input int g, input logic [DATA_W-1:0] vin);
		answer_t a;
		logic [DATA_W-1:0] v;
		int p;
		int hole;
		int last;
		int moved;
		a = '{st: ST_OK, id: '0, vals: '0};
		case (k)
			KIND_SURVEY: begin
				a.st = ST_MISS;
				p = 0;
				if (!fs && held[g][ent])
					p = where[g][ent] + 1;
				for (; p < fill[g]; p++) begin
					if (collect(id_list[g][p], m, v)) begin
						a.st = ST_OK;
						a.id = id_list[g][p];
						a.vals = v;
						break;
					end
				end
			end
			KIND_UPDATE: begin
				for (int c = 0; c < NUM_COLUMNS; c++) begin
					if (m[c]) begin
						if (!held[c][ent]) begin
							id_list[c][fill[c]] = ID_W'(ent);
							where[c][ent] = fill[c];
							held[c][ent] = 1'b1;
							fill[c]++;
						end
						val_list[c][where[c][ent]] = vin[16*c +: 16];
					end
				end
			end
			KIND_ERASE: begin
				for (int c = 0; c < NUM_COLUMNS; c++) begin
					if (m[c] && held[c][ent] && fill[c] != 0) begin
						hole = where[c][ent];
						last = fill[c] - 1;
						fill[c] = CNT_W'(last);
						moved = id_list[c][last];
						id_list[c][hole] = ID_W'(moved);
						val_list[c][hole] = val_list[c][last];
						where[c][moved] = CNT_W'(hole);
						held[c][ent] = 1'b0;
					end
				end
			end
			default: begin
				if (collect(ent, m, v)) begin
					a.id = ID_W'(ent);
					a.vals = v;
				end else begin
					a.st = ST_MISS;
				end
			end
		endcase
		answer_q.push_back(a);
	endtask

	initial begin
		fail_count = 0;
		for (int c = 0; c < NUM_COLUMNS; c++) begin
			fill[c] = '0;
			for (int i = 0; i < MAX_IDS; i++)
				held[c][i] = 1'b0;
		end
	end

	always @(posedge clk) begin
		answer_t w;
		if (arst_n && in_valid && !in_stall)
			apply(kind_t'(kind), entity_id, from_start, column_mask, guide_column, value_in);
		if (arst_n && out_valid && !out_stall) begin
			if (answer_q.size() == 0) begin
				report("unexpected word", DATA_W'(status), '0);
			end else begin
				w = answer_q.pop_front();
				if (status !== w.st)
					report("status", DATA_W'(status), DATA_W'(w.st));
				if (found_id !== w.id)
					report("found_id", DATA_W'(found_id), DATA_W'(w.id));
				if (value_out !== w.vals)
					report("value_out", value_out, w.vals);
			end
		end
	end

endmodule

// ===== dv/sparse_set_column_store_tb.sv =====
// Testbench top for the sparse-set column store: stimulus, idling and verdict.
`timescale 1ns / 100ps
module sparse_set_column_store_tb import ssc_pkg::*;;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [1:0]        kind;
	logic [ID_W-1:0]   entity_id;
	logic              from_start;
	logic [3:0]        column_mask;
	logic [COL_W-1:0]  guide_column;
	logic [DATA_W-1:0] value_in;
	logic              out_valid;
	logic              out_stall;
	logic [1:0]        status;
	logic [ID_W-1:0]   found_id;
	logic [DATA_W-1:0] value_out;
	int                fail_count;
	int                pending;
	int                send_idle;
	int                recv_idle;

	sparse_set_column_store u_top (.*);

	sparse_set_column_store_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#4000000;
		$display("status: fail");
		$finish;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_stall <= 1'b1;
		else
			out_stall <= ($urandom_range(99) < recv_idle);
	end

	// Present one word, hold it until it is taken.
	task automatic send(input kind_t k, input int ent, input logic fs, input logic [3:0] m,
		input int g, input logic [DATA_W-1:0] v);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		entity_id <= ID_W'(ent);
		from_start <= fs;
		column_mask <= m;
		guide_column <= COL_W'(g);
		value_in <= v;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// Mostly small id pool so hits, erases and swaps happen often.
	task automatic random_word();
		int ent;
		int r;
		ent = ($urandom_range(9) == 0) ? $urandom_range(1023) : $urandom_range(40);
		r = $urandom_range(99);
		send(kind_t'(r < 40 ? KIND_UPDATE : r < 60 ? KIND_ERASE : r < 80 ? KIND_LOOKUP
			: KIND_SURVEY), ent, 1'($urandom_range(1)), 4'($urandom_range(15)),
			$urandom_range(3), {$urandom, $urandom});
	endtask

	initial begin
		int guard;
		in_valid = 1'b0;
		kind = KIND_UPDATE;
		entity_id = '0;
		from_start = 1'b0;
		column_mask = '0;
		guide_column = '0;
		value_in = '0;
		send_idle = 13;
		recv_idle = 60;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send(KIND_LOOKUP, 0, 0, 4'hf, 0, '0);
		send(KIND_SURVEY, 0, 1, 4'hf, 0, '0);
		send(KIND_UPDATE, 0, 0, 4'hf, 0, '1);
		send(KIND_UPDATE, 1023, 0, 4'hf, 0, 64'h0123_4567_89ab_cdef);
		send(KIND_UPDATE, 5, 0, 4'b0101, 0, 64'hfedc_ba98_7654_3210);
		send(KIND_UPDATE, 7, 0, 4'h0, 0, '1);
		send(KIND_UPDATE, 0, 0, 4'b0010, 0, 64'h0000_0000_5555_0000);
		send(KIND_LOOKUP, 0, 0, 4'hf, 0, '0);
		send(KIND_LOOKUP, 5, 0, 4'hf, 0, '0);
		send(KIND_LOOKUP, 5, 0, 4'h0, 0, '0);
		send(KIND_LOOKUP, 1023, 0, 4'b1000, 0, '0);
		send(KIND_SURVEY, 0, 1, 4'b0101, 0, '0);
		send(KIND_SURVEY, 0, 0, 4'b0101, 0, '0);
		send(KIND_SURVEY, 99, 0, 4'h0, 3, '0);
		send(KIND_SURVEY, 1023, 0, 4'hf, 2, '0);
		send(KIND_ERASE, 0, 0, 4'hf, 0, '0);
		send(KIND_ERASE, 99, 0, 4'hf, 0, '0);
		send(KIND_ERASE, 5, 0, 4'h0, 0, '0);
		send(KIND_ERASE, 1023, 0, 4'b0001, 0, '0);
		send(KIND_LOOKUP, 1023, 0, 4'hf, 0, '0);
		send(KIND_SURVEY, 0, 1, 4'hf, 1, '0);
		for (int i = 0; i < 200; i++)
			random_word();
		send_idle = 60;
		recv_idle = 13;
		for (int i = 0; i < 200; i++)
			random_word();
		send_idle = 0;
		recv_idle = 0;
		for (int i = 0; i < 200; i++)
			random_word();
		in_valid <= 1'b0;
		guard = 0;
		while (pending != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (200) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
